/* design/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Window depth, counter widths, register codes and the burst descriptor that
// travels from the window logic to the result emitter.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;

	// The register fields hold at most eight bytes each.
	localparam int CFG_BYTES = 8;
	localparam int CFG_W     = 8 * CFG_BYTES;
	localparam int CFG_SEL_W = $clog2(CFG_BYTES);
	localparam int LEN_W     = 4;
	localparam int REG_IDX_W = 2;

	localparam int WIN_DEPTH = (MAX_PATTERN < CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;
	localparam int REP_DEPTH = (MAX_REPLACEMENT < CFG_BYTES) ? MAX_REPLACEMENT : CFG_BYTES;

	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int REP_CNT_W = $clog2(REP_DEPTH + 1);
	localparam int RES_W     = $clog2(WIN_DEPTH + REP_DEPTH + 1);

	typedef logic [7:0] byte_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_LENGTH,
		REG_PATTERN_BYTES,
		REG_REPLACEMENT_LENGTH,
		REG_REPLACEMENT_BYTES
	} cfg_reg_t;

	// One item's worth of results: head_cnt window bytes taken oldest first
	// from the snapshot, followed by replacement bytes, nres results in all.
	typedef struct packed {
		byte_t [WIN_DEPTH-1:0] snap;
		logic [WIN_IDX_W-1:0]  base;
		logic [CNT_W-1:0]      head_cnt;
		logic [RES_W-1:0]      nres;
		logic                  bare;
		logic                  eos;
	} burst_t;

endpackage

/* design/stream_find_and_replace.sv */
// ----------------------------------------------------------------------------
// stream_find_and_replace: streaming pattern substitution
// Replaces every non-overlapping occurrence of a programmed byte pattern in
// a byte stream with a programmed replacement, scanning left to right.
//
// Usage: program pattern_length, pattern_bytes, replacement_length and
// replacement_bytes through the write port (cfg_we, cfg_index, cfg_data)
// while the block is idle. Bytes enter on in_valid/in_stall with
// end_of_stream set on the last byte; results leave on out_valid/out_stall,
// last_of_run closing the results of each input item and stream_done the
// final result of a stream. An end-of-stream byte with nothing to emit
// gives one result with byte_valid low.
// Path: an accepted item is held in the burst register and its results
// leave through the output register. While the receiver does not stall:
// one item per cycle if each item yields at most one result, and an item
// yielding more holds the input as the emitter issues one result per cycle.
// The history is a chain of byte cells that all compare in parallel.
// Reset empties the window, drops any pending results and restores the
// register defaults. A stalled receiver holds the output register; one more
// item is still taken into the burst register before the input stalls.
// ----------------------------------------------------------------------------
module stream_find_and_replace (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfr_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic                          last_of_run,
	output logic                          stream_done
);
	import sfr_pkg::*;

	logic [LEN_W-1:0]      plen_q;
	logic [CFG_W-1:0]      pbytes_q;
	logic [LEN_W-1:0]      rlen_q;
	logic [CFG_W-1:0]      rbytes_q;
	logic [CNT_W-1:0]      count_q;

	logic [CNT_W-1:0]      p_eff;
	logic [REP_CNT_W-1:0]  r_eff;
	logic [CNT_W-1:0]      cnt_app;
	logic [CNT_W-1:0]      excess;
	logic [CNT_W-1:0]      head_cnt;
	logic [REP_CNT_W-1:0]  rep_cnt;
	logic [RES_W-1:0]      n_total;
	logic                  full;
	logic                  match;
	logic                  bare;
	logic                  ready;
	logic                  in_accept;

	byte_t [CFG_BYTES-1:0] pat_arr;
	byte_t [WIN_DEPTH-1:0] cell_d;
	byte_t [WIN_DEPTH-1:0] cell_held;
	byte_t [WIN_DEPTH-1:0] cell_pat;
	logic [WIN_DEPTH-1:0]  cell_eq;
	logic [WIN_DEPTH-1:0]  eq_masked;
	burst_t                burst;

	assign in_stall  = !ready;
	assign in_accept = in_valid && ready;
	assign pat_arr   = pbytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= LEN_W'(1);
			pbytes_q <= '0;
			rlen_q   <= '0;
			rbytes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LENGTH:     plen_q   <= cfg_data[LEN_W-1:0];
				REG_PATTERN_BYTES:      pbytes_q <= cfg_data;
				REG_REPLACEMENT_LENGTH: rlen_q   <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  rbytes_q <= cfg_data;
				default:                plen_q   <= plen_q;
			endcase
		end
	end

	// Clamp the programmed lengths to what the window and buffer can hold.
	always_comb begin
		if (plen_q == '0) begin
			p_eff = CNT_W'(1);
		end else if (plen_q > LEN_W'(WIN_DEPTH)) begin
			p_eff = CNT_W'(WIN_DEPTH);
		end else begin
			p_eff = CNT_W'(plen_q);
		end
		if (rlen_q > LEN_W'(REP_DEPTH)) begin
			r_eff = REP_CNT_W'(REP_DEPTH);
		end else begin
			r_eff = REP_CNT_W'(rlen_q);
		end
	end

	// Cell 0 takes the newest byte; cell i holds the byte i places back and
	// lines up with pattern byte p-1-i.
	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_d[i] = in_byte;
		end else begin : g_body
			assign cell_d[i] = cell_held[i-1];
		end
		assign cell_pat[i]  = pat_arr[CFG_SEL_W'(p_eff - CNT_W'(1) - CNT_W'(i))];
		assign eq_masked[i] = cell_eq[i] || (CNT_W'(i) >= p_eff);

		sfr_cell u_cell (
			.clk   (clk),
			.shift (in_accept),
			.d     (cell_d[i]),
			.pat   (cell_pat[i]),
			.held  (cell_held[i]),
			.eq    (cell_eq[i])
		);
	end

	always_comb begin
		cnt_app = count_q + CNT_W'(1);
		full    = (cnt_app >= p_eff);
		excess  = (cnt_app > p_eff) ? (cnt_app - p_eff) : '0;
		match   = full && (&eq_masked);
		if (match) begin
			head_cnt = excess;
		end else if (end_of_stream) begin
			head_cnt = cnt_app;
		end else if (full) begin
			head_cnt = excess + CNT_W'(1);
		end else begin
			head_cnt = '0;
		end
		rep_cnt = match ? r_eff : '0;
		n_total = RES_W'(head_cnt) + RES_W'(rep_cnt);
		bare    = end_of_stream && (n_total == '0);

		burst.snap     = cell_d;
		burst.base     = WIN_IDX_W'(cnt_app - CNT_W'(1));
		burst.head_cnt = head_cnt;
		burst.nres     = bare ? RES_W'(1) : n_total;
		burst.bare     = bare;
		burst.eos      = end_of_stream;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_accept) begin
			if (match || end_of_stream) begin
				count_q <= '0;
			end else if (full) begin
				count_q <= p_eff - CNT_W'(1);
			end else begin
				count_q <= cnt_app;
			end
		end
	end

	sfr_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (in_accept),
		.burst       (burst),
		.rep_bytes   (rbytes_q),
		.ready       (ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.stream_done (stream_done)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(WIN_DEPTH))
		else $error("window holds a full depth between items");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && end_of_stream |=> count_q == '0)
		else $error("window not emptied after end of stream");

	a_eos_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && end_of_stream |-> burst.nres != '0)
		else $error("end of stream item produced no result");

endmodule

/* design/sfr_cell.sv */
// ----------------------------------------------------------------------------
// sfr_cell: one byte cell of the history chain
// Holds one stream byte, hands it to the next older cell on every accepted
// item and compares the byte it is about to take with its pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell (
	input  logic          clk,
	input  logic          shift,
	input  sfr_pkg::byte_t d,
	input  sfr_pkg::byte_t pat,
	output sfr_pkg::byte_t held,
	output logic          eq
);
	import sfr_pkg::*;

	byte_t held_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			held_q <= d;
		end
	end

	assign held = held_q;
	assign eq   = (d == pat);

endmodule

/* design/sfr_emitter.sv */
// ----------------------------------------------------------------------------
// sfr_emitter: result sequencer and output register
// Holds the burst of one item and hands its results out one per cycle,
// while the receiver does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
module sfr_emitter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  sfr_pkg::burst_t            burst,
	input  logic [sfr_pkg::CFG_W-1:0]  rep_bytes,
	output logic                       ready,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       byte_valid,
	output logic                       last_of_run,
	output logic                       stream_done
);
	import sfr_pkg::*;

	burst_t              burst_q;
	logic                busy_q;
	logic [RES_W-1:0]    idx_q;
	logic                out_valid_q;
	byte_t               out_byte_q;
	logic                byte_valid_q;
	logic                last_of_run_q;
	logic                stream_done_q;

	logic                out_take;
	logic                emit_go;
	logic                is_last;
	logic                in_head;
	logic [RES_W-1:0]    rep_idx;
	byte_t [CFG_BYTES-1:0] rep_arr;
	byte_t               head_byte;
	byte_t               sel_byte;

	assign rep_arr  = rep_bytes;
	assign out_take = !out_valid_q || !out_stall;
	assign emit_go  = busy_q && out_take;
	assign is_last  = (idx_q == burst_q.nres - RES_W'(1));
	assign ready    = !busy_q || (emit_go && is_last);

	always_comb begin
		in_head   = (idx_q < RES_W'(burst_q.head_cnt));
		rep_idx   = idx_q - RES_W'(burst_q.head_cnt);
		head_byte = burst_q.snap[burst_q.base - idx_q[WIN_IDX_W-1:0]];
		if (burst_q.bare) begin
			sel_byte = '0;
		end else if (in_head) begin
			sel_byte = head_byte;
		end else begin
			sel_byte = rep_arr[CFG_SEL_W'(rep_idx)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= (burst.nres != '0);
				idx_q  <= '0;
			end else if (emit_go) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + RES_W'(1);
				end
			end
			if (out_take) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= burst;
		end
		if (emit_go) begin
			out_byte_q    <= sel_byte;
			byte_valid_q  <= !burst_q.bare;
			last_of_run_q <= is_last;
			stream_done_q <= is_last && burst_q.eos;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_valid  = byte_valid_q;
	assign last_of_run = last_of_run_q;
	assign stream_done = stream_done_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < burst_q.nres)
		else $error("result index ran past the end of its burst");

	a_bare_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && burst_q.bare |-> burst_q.nres == RES_W'(1))
		else $error("bare end marker burst holds more than one result");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stream_done_q |-> last_of_run_q)
		else $error("stream end flagged on a result that does not close its run");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for stream_find_and_replace
// Drives byte streams and register settings into the block and predicts
// each output byte with a local model of the sliding-window substitution.
// Every output item is compared field by field in arrival order. Directed
// cases come first, then random streams under several idle mixes, then a
// long output hold-off that makes the block stall its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 300;

	typedef struct packed {
		byte_t data;
		logic  valid;
		logic  last;
		logic  done;
	} text_result_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [7:0]           in_byte       = '0;
	logic                 end_of_stream = 1'b0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [7:0]           out_byte;
	logic                 byte_valid;
	logic                 last_of_run;
	logic                 stream_done;

	stream_find_and_replace u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.last_of_run   (last_of_run),
		.stream_done   (stream_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Local copy of the registers and the match window.
	logic [3:0]   m_plen = 4'd1;
	logic [63:0]  m_pat  = '0;
	logic [3:0]   m_rlen = 4'd0;
	logic [63:0]  m_rep  = '0;
	byte_t        win [WIN_DEPTH];
	int unsigned  win_fill = 0;

	text_result_t expected_out_q[$];
	int unsigned  fail_count    = 0;
	int unsigned  items_sent    = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;
	int unsigned  hold_start    = 0;
	int unsigned  hold_seen     = 0;
	int unsigned  hold_left     = 0;
	int unsigned  quiet_cycles  = 0;

	function automatic int unsigned pattern_span();
		if (m_plen == 0)
			return 1;
		if (m_plen > WIN_DEPTH)
			return WIN_DEPTH;
		return m_plen;
	endfunction

	function automatic text_result_t text_byte(byte_t b);
		text_result_t r;
		r.data  = b;
		r.valid = 1'b1;
		r.last  = 1'b0;
		r.done  = 1'b0;
		return r;
	endfunction

	function automatic void drop_oldest();
		for (int i = 1; i < WIN_DEPTH; i++)
			win[i-1] = win[i];
		win[WIN_DEPTH-1] = '0;
		if (win_fill > 0)
			win_fill--;
	endfunction

	function automatic void clear_window();
		foreach (win[i])
			win[i] = '0;
		win_fill = 0;
	endfunction

	// Works out every output item that one input byte causes.
	function automatic void predict_replace(byte_t b, logic eos);
		text_result_t run_q[$];
		text_result_t bare;
		int unsigned  plen;
		int unsigned  rlen;
		logic         hit;
		plen = pattern_span();
		rlen = (m_rlen > REP_DEPTH) ? REP_DEPTH : m_rlen;
		while (win_fill >= WIN_DEPTH) begin
			run_q.insert(run_q.size(), text_byte(win[0]));
			drop_oldest();
		end
		win[win_fill] = b;
		win_fill++;
		// A shorter pattern than before lets the surplus old bytes through.
		while (win_fill > plen) begin
			run_q.insert(run_q.size(), text_byte(win[0]));
			drop_oldest();
		end
		if (win_fill == plen) begin
			hit = 1'b1;
			for (int i = 0; i < plen; i++)
				if (win[i] != m_pat[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < rlen; i++)
					run_q.insert(run_q.size(), text_byte(m_rep[8*i +: 8]));
				clear_window();
			end else begin
				run_q.insert(run_q.size(), text_byte(win[0]));
				drop_oldest();
			end
		end
		if (eos) begin
			for (int i = 0; i < win_fill; i++)
				run_q.insert(run_q.size(), text_byte(win[i]));
			clear_window();
			if (run_q.size() == 0) begin
				bare = '0;
				run_q.insert(run_q.size(), bare);
			end
			run_q[run_q.size()-1].done = 1'b1;
		end
		if (run_q.size() > 0)
			run_q[run_q.size()-1].last = 1'b1;
		foreach (run_q[i])
			expected_out_q.insert(expected_out_q.size(), run_q[i]);
	endfunction

	task automatic feed_byte(input byte_t b, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		end_of_stream <= eos;
		do
			@(posedge clk);
		while (in_stall);
		predict_replace(b, eos);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_out_q.size() != 0)
			@(posedge clk);
		// An item that makes no output may still sit inside the block.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back; the length registers get
	// random upper bits to show that only the low four count.
	task automatic program_regs(input logic [3:0] plen, input logic [63:0] pat,
			input logic [3:0] rlen, input logic [63:0] rep);
		logic [63:0] word;
		word = {$urandom, $urandom};
		word[3:0] = plen;
		cfg_we    <= 1'b1;
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data  <= word;
		@(posedge clk);
		cfg_index <= REG_PATTERN_BYTES;
		cfg_data  <= pat;
		@(posedge clk);
		word = {$urandom, $urandom};
		word[3:0] = rlen;
		cfg_index <= REG_REPLACEMENT_LENGTH;
		cfg_data  <= word;
		@(posedge clk);
		cfg_index <= REG_REPLACEMENT_BYTES;
		cfg_data  <= rep;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_plen = plen;
		m_pat  = pat;
		m_rlen = rlen;
		m_rep  = rep;
		@(posedge clk);
	endtask

	task automatic program_random();
		logic [3:0]  plen;
		logic [3:0]  rlen;
		logic [63:0] pat;
		plen = ($urandom_range(99) < 10) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
		rlen = ($urandom_range(99) < 10) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
		if ($urandom_range(99) < 50) begin
			for (int i = 0; i < 8; i++)
				pat[8*i +: 8] = byte_t'(8'h30 + $urandom_range(0, 3));
		end else
			pat = {$urandom, $urandom};
		program_regs(plen, pat, rlen, {$urandom, $urandom});
	endtask

	task automatic test_reset_values();
		// Defaults: a one-byte pattern of zero that is deleted.
		feed_byte(8'h00, 1'b0);
		feed_byte(8'hFF, 1'b0);
		feed_byte(8'h00, 1'b1);
		drain_results();
	endtask

	task automatic test_replace_basic();
		program_regs(4'd2, 64'h6261, 4'd3, 64'h5A5958);
		feed_byte(8'h61, 1'b0);
		feed_byte(8'h61, 1'b0);
		feed_byte(8'h62, 1'b0);
		feed_byte(8'h78, 1'b0);
		feed_byte(8'h62, 1'b1);
		drain_results();
	endtask

	task automatic test_saturated_lengths();
		program_regs(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, {$urandom, $urandom});
		repeat (8) feed_byte(8'hFF, 1'b0);
		feed_byte(8'h00, 1'b1);
		drain_results();
	endtask

	task automatic test_zero_pattern_length();
		program_regs(4'd0, 64'h7E, 4'd0, 64'h0);
		feed_byte(8'h01, 1'b0);
		feed_byte(8'h7E, 1'b1);
		drain_results();
	endtask

	task automatic test_pattern_shrink();
		program_regs(4'd8, {$urandom, $urandom}, 4'd4, {$urandom, $urandom});
		for (int i = 0; i < 6; i++)
			feed_byte(byte_t'(8'h10 + i), 1'b0);
		drain_results();
		// The window now holds more bytes than the new pattern length.
		program_regs(4'd2, 64'hA515, 4'd8, {$urandom, $urandom});
		feed_byte(8'hA5, 1'b1);
		drain_results();
	endtask

	task automatic test_random_streams(input int unsigned item_goal);
		byte_t       text_q[$];
		int unsigned goal_at;
		int unsigned stream_len;
		int unsigned span;
		int unsigned pick;
		int unsigned n;
		logic        closing;
		goal_at = items_sent + item_goal;
		while (items_sent < goal_at) begin
			if ($urandom_range(99) < 50) begin
				drain_results();
				program_random();
			end
			span = pattern_span();
			stream_len = $urandom_range(1, 24);
			text_q.delete();
			if ($urandom_range(99) < 10) begin
				repeat (stream_len) text_q.insert(text_q.size(), byte_t'($urandom));
			end else begin
				while (text_q.size() < stream_len) begin
					pick = $urandom_range(99);
					if (pick < 45) begin
						for (int k = 0; k < span; k++)
							text_q.insert(text_q.size(), m_pat[8*k +: 8]);
					end else if (pick < 65 && span > 1) begin
						n = $urandom_range(1, span - 1);
						for (int k = 0; k < n; k++)
							text_q.insert(text_q.size(), m_pat[8*k +: 8]);
					end else if (pick < 90) begin
						repeat ($urandom_range(1, 3))
							text_q.insert(text_q.size(),
								byte_t'(8'h30 + $urandom_range(0, 3)));
					end else
						repeat ($urandom_range(1, 2))
							text_q.insert(text_q.size(), byte_t'($urandom));
				end
			end
			// Some streams stay open so that a later setting meets a full window.
			closing = ($urandom_range(99) < 85);
			foreach (text_q[i])
				feed_byte(text_q[i], closing && (i == text_q.size() - 1));
		end
		drain_results();
	endtask

	task automatic test_output_backpressure();
		int unsigned saved_send;
		saved_send    = send_idle_pct;
		send_idle_pct = 0;
		program_regs(4'd3, 64'h333231, 4'd5, {$urandom, $urandom});
		hold_start++;
		for (int i = 0; i < 40; i++)
			feed_byte(($urandom_range(99) < 60) ? byte_t'(8'h31 + i % 3) : byte_t'($urandom),
				i == 39);
		drain_results();
		send_idle_pct = saved_send;
	endtask

	// Receiver: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_seen != hold_start) begin
			hold_seen = hold_start;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		text_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out_q.size() == 0) begin
				fail_count++;
				$display("%0t unexpected output: expected none got %02h/%0d/%0d/%0d",
					$time, out_byte, byte_valid, last_of_run, stream_done);
			end else begin
				want = expected_out_q.pop_front();
				if (out_byte !== want.data || byte_valid !== want.valid ||
						last_of_run !== want.last || stream_done !== want.done) begin
					fail_count++;
					$display("%0t mismatch: expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
						$time, want.data, want.valid, want.last, want.done,
						out_byte, byte_valid, last_of_run, stream_done);
				end
			end
		end
	end

	// Ends the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		clear_window();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_replace_basic();
		test_saturated_lengths();
		test_zero_pattern_length();
		test_pattern_shrink();
		send_idle_pct = 38;
		recv_idle_pct = 56;
		test_random_streams(125);
		send_idle_pct = 56;
		recv_idle_pct = 38;
		test_random_streams(125);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_streams(125);
		test_output_backpressure();
		drain_results();
		if (fail_count == 0 && expected_out_q.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

/* filelist.f */
design/sfr_pkg.sv
design/sfr_cell.sv
design/sfr_emitter.sv
design/stream_find_and_replace.sv
verif/tb.sv
